### sv/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared constants, opcodes and types for the drum step sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int STEP_COUNT_DEF  = 16;
  localparam int VOICE_COUNT_DEF = 6;

  localparam int OPCODE_W = 2;
  localparam int DELTA_W  = 5;
  localparam int TIME_W   = 32;
  localparam int SWING_W  = 4;
  localparam int MASK_W   = 6;
  localparam int POS_W    = 4;
  localparam int VOICE_W  = 3;

  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_MOVE   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_VOICE  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_TOGGLE = 2'd3;

  typedef struct packed {
    logic tick;
    logic move;
    logic next_voice;
    logic toggle;
  } dss_op_t;

  typedef struct packed {
    logic [MASK_W-1:0]  trigger_mask;
    logic               step_fired;
    logic [POS_W-1:0]   play_position;
    logic [POS_W-1:0]   cursor_position;
    logic [VOICE_W-1:0] chosen_voice;
    logic               cell_value;
  } dss_result_t;

  function automatic dss_op_t dss_decode(input logic [OPCODE_W-1:0] opcode);
    dss_op_t op;
    op = '0;
    unique case (opcode)
      OP_TICK:   op.tick       = 1'b1;
      OP_MOVE:   op.move       = 1'b1;
      OP_VOICE:  op.next_voice = 1'b1;
      OP_TOGGLE: op.toggle     = 1'b1;
      default:   op = '0;
    endcase
    return op;
  endfunction

endpackage

### sv/drum_step_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_step_sequencer
// An accepted item passes the input reg and then the result reg before result valid.
// Throughput: one item per cycle while out_stall is low; state update is a single pass between regs.
// A stalled result holds while the input register still takes one more item.
// Reset (rst_n low, synchronous): pattern cleared, play step at last step,
// cursor, voice, last fire time and swing delay zero, both channels empty.
// ----------------------------------------------------------------------------
module drum_step_sequencer #(
  parameter int STEP_COUNT  = dss_pkg::STEP_COUNT_DEF,
  parameter int VOICE_COUNT = dss_pkg::VOICE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dss_pkg::SWING_W-1:0]   cfg_swing_delay_ms,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dss_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic signed [dss_pkg::DELTA_W-1:0] in_cursor_delta,
  input  logic [dss_pkg::TIME_W-1:0]    in_now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dss_pkg::MASK_W-1:0]    out_trigger_mask,
  output logic                          out_step_fired,
  output logic [dss_pkg::POS_W-1:0]     out_play_position,
  output logic [dss_pkg::POS_W-1:0]     out_cursor_position,
  output logic [dss_pkg::VOICE_W-1:0]   out_chosen_voice,
  output logic                          out_cell_value
);
  import dss_pkg::*;

  logic [SWING_W-1:0]  swing_r;
  logic                s1_valid_r;
  logic [OPCODE_W-1:0] s1_opcode_r;
  logic [DELTA_W-1:0]  s1_delta_r;
  logic [TIME_W-1:0]   s1_now_r;
  logic                out_valid_r;
  dss_result_t         out_r;
  dss_result_t         result;
  logic                out_adv;
  logic                s1_fire;
  logic                in_take;

  assign cfg_ready = 1'b1;
  assign out_adv   = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_adv;
  assign in_stall  = s1_valid_r && !out_adv;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swing_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      swing_r <= cfg_swing_delay_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_opcode_r <= in_opcode;
      s1_delta_r  <= in_cursor_delta;
      s1_now_r    <= in_now_ms;
    end
  end

  dss_seq_state #(
    .STEP_COUNT  (STEP_COUNT),
    .VOICE_COUNT (VOICE_COUNT)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .commit         (s1_fire),
    .opcode         (s1_opcode_r),
    .cursor_delta   (s1_delta_r),
    .now_ms         (s1_now_r),
    .swing_delay_ms (swing_r),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_trigger_mask    = out_r.trigger_mask;
  assign out_step_fired      = out_r.step_fired;
  assign out_play_position   = out_r.play_position;
  assign out_cursor_position = out_r.cursor_position;
  assign out_chosen_voice    = out_r.chosen_voice;
  assign out_cell_value      = out_r.cell_value;

  a_no_mask_unfired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.step_fired |-> out_r.trigger_mask == '0)
    else $error("trigger mask set on an item that fired no step");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free pipeline");

  a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("item processed but no result presented");

endmodule

### sv/dss_pattern.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pattern
// Pattern bit matrix, one row of step bits per voice. Toggle write, column
// read at the play step, single bit read at the selected voice and cursor.
// ----------------------------------------------------------------------------
module dss_pattern #(
  parameter int STEP_COUNT  = dss_pkg::STEP_COUNT_DEF,
  parameter int VOICE_COUNT = dss_pkg::VOICE_COUNT_DEF,
  parameter int SW          = $clog2(STEP_COUNT),
  parameter int VW          = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   commit,
  input  dss_pkg::dss_op_t       op,
  input  logic [VW-1:0]          voice_cur,
  input  logic [SW-1:0]          cursor_cur,
  input  logic [SW-1:0]          play_nxt,
  input  logic [VW-1:0]          voice_nxt,
  input  logic [SW-1:0]          cursor_nxt,
  output logic [VOICE_COUNT-1:0] col_bits,
  output logic                   cell_bit
);
  import dss_pkg::*;

  logic [STEP_COUNT-1:0] rows_r [VOICE_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < VOICE_COUNT; v++) begin
        rows_r[v] <= '0;
      end
    end else if (commit && op.toggle) begin
      for (int v = 0; v < VOICE_COUNT; v++) begin
        if (voice_cur == VW'(v)) begin
          rows_r[v][cursor_cur] <= ~rows_r[v][cursor_cur];
        end
      end
    end
  end

  always_comb begin
    for (int v = 0; v < VOICE_COUNT; v++) begin
      col_bits[v] = rows_r[v][play_nxt];
    end
  end

  // toggle leaves cursor and voice alone, so the new bit is the old one flipped
  assign cell_bit = rows_r[voice_nxt][cursor_nxt] ^ op.toggle;

endmodule

### sv/dss_seq_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_seq_state
// Play position, edit cursor, selected voice and last fire time, with the
// per-item update logic and result formation.
// ----------------------------------------------------------------------------
module dss_seq_state #(
  parameter int STEP_COUNT  = dss_pkg::STEP_COUNT_DEF,
  parameter int VOICE_COUNT = dss_pkg::VOICE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            commit,
  input  logic [dss_pkg::OPCODE_W-1:0]    opcode,
  input  logic [dss_pkg::DELTA_W-1:0]     cursor_delta,
  input  logic [dss_pkg::TIME_W-1:0]      now_ms,
  input  logic [dss_pkg::SWING_W-1:0]     swing_delay_ms,
  output dss_pkg::dss_result_t            result
);
  import dss_pkg::*;

  localparam int SW = $clog2(STEP_COUNT);
  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int DELTA_N = 2 ** DELTA_W;
  localparam logic [SW-1:0] LAST_STEP  = SW'(STEP_COUNT - 1);
  localparam logic [VW-1:0] LAST_VOICE = VW'(VOICE_COUNT - 1);
  localparam logic [SW:0]   STEP_L     = (SW + 1)'(STEP_COUNT);

  logic [SW-1:0]     play_r, play_nxt;
  logic [SW-1:0]     cursor_r, cursor_nxt;
  logic [VW-1:0]     voice_r, voice_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;

  dss_op_t                op;
  logic [SW-1:0]          dmod_tbl [DELTA_N];
  logic [SW:0]            csum;
  logic                   swallow;
  logic                   fired;
  logic [TIME_W-1:0]      elapsed;
  logic [VOICE_COUNT-1:0] col_bits;
  logic                   cell_bit;
  logic [VOICE_COUNT-1:0] mask_v;
  logic [VOICE_COUNT+MASK_W-1:0] mask_ext;
  logic [SW+POS_W-1:0]    play_ext, cursor_ext;
  logic [VW+VOICE_W-1:0]  voice_ext;

  // delta reduced modulo the step count, two's complement index
  for (genvar i = 0; i < DELTA_N; i++) begin : g_dmod
    localparam int DV = (i >= DELTA_N / 2) ? i - DELTA_N : i;
    localparam int DM = ((DV % STEP_COUNT) + STEP_COUNT) % STEP_COUNT;
    assign dmod_tbl[i] = SW'(DM);
  end

  assign op = dss_decode(opcode);

  always_comb begin
    play_nxt   = play_r;
    cursor_nxt = cursor_r;
    voice_nxt  = voice_r;
    last_nxt   = last_r;
    swallow    = 1'b0;
    fired      = 1'b0;
    elapsed    = now_ms - last_r;
    csum       = {1'b0, cursor_r} + {1'b0, dmod_tbl[cursor_delta]};
    if (op.tick) begin
      play_nxt = (play_r == LAST_STEP) ? '0 : play_r + 1'b1;
      swallow  = play_nxt[0] && (swing_delay_ms != '0) &&
                 (elapsed < {{(TIME_W-SWING_W){1'b0}}, swing_delay_ms});
      fired    = !swallow;
      if (!swallow) begin
        last_nxt = now_ms;
      end
    end
    if (op.move) begin
      cursor_nxt = (csum >= STEP_L) ? SW'(csum - STEP_L) : csum[SW-1:0];
    end
    if (op.next_voice) begin
      voice_nxt = (voice_r == LAST_VOICE) ? '0 : voice_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r   <= LAST_STEP;
      cursor_r <= '0;
      voice_r  <= '0;
      last_r   <= '0;
    end else if (commit) begin
      play_r   <= play_nxt;
      cursor_r <= cursor_nxt;
      voice_r  <= voice_nxt;
      last_r   <= last_nxt;
    end
  end

  dss_pattern #(
    .STEP_COUNT  (STEP_COUNT),
    .VOICE_COUNT (VOICE_COUNT),
    .SW          (SW),
    .VW          (VW)
  ) u_pattern (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (commit),
    .op         (op),
    .voice_cur  (voice_r),
    .cursor_cur (cursor_r),
    .play_nxt   (play_nxt),
    .voice_nxt  (voice_nxt),
    .cursor_nxt (cursor_nxt),
    .col_bits   (col_bits),
    .cell_bit   (cell_bit)
  );

  assign mask_v     = fired ? col_bits : '0;
  assign mask_ext   = {{MASK_W{1'b0}}, mask_v};
  assign play_ext   = {{POS_W{1'b0}}, play_nxt};
  assign cursor_ext = {{POS_W{1'b0}}, cursor_nxt};
  assign voice_ext  = {{VOICE_W{1'b0}}, voice_nxt};

  always_comb begin
    result.trigger_mask    = mask_ext[MASK_W-1:0];
    result.step_fired      = fired;
    result.play_position   = play_ext[POS_W-1:0];
    result.cursor_position = cursor_ext[POS_W-1:0];
    result.chosen_voice    = voice_ext[VOICE_W-1:0];
    result.cell_value      = cell_bit;
  end

endmodule
